### rtl/core/nested_peak_usage_tracker_macros.svh
// Assertion macros shared by the tracker modules.
`ifndef NESTED_PEAK_USAGE_TRACKER_MACROS_SVH
`define NESTED_PEAK_USAGE_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### rtl/core/npt_pkg.sv
package npt_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OP_W = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W = 5;
    // One mark entry holds the start usage (low half) and the sample maximum of
    // its segment (high half).
    localparam int unsigned ENTRY_W = 2 * DATA_W;
    localparam int unsigned CFG_ADDR_W = 1;

    localparam int unsigned DEFAULT_MARK_DEPTH = 16;
    localparam logic [DATA_W-1:0] STACK_RESET = 32'h0002_0000;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PUSH    = 2'd2,
        OP_POP     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BINARY_BYTES = 1'b0,
        REG_STACK_BYTES  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_req_t;

endpackage

### rtl/core/nested_peak_usage_tracker.sv
// A result is in the output register in the cycle after its request is accepted.
// Allocate, release and push leave the core free for a new request; a pop that leaves a
// mark open stalls requests while the new top mark is read back from the one-port memory.
// Reset (aresetn, synchronous, active low) clears the allocation total, the mark count
// and the output valid, and sets binary_bytes to 0 and stack_bytes to 0x20000.
// The mark memory is not cleared: an entry is always written by a push before it is read.
`include "nested_peak_usage_tracker_macros.svh"

module nested_peak_usage_tracker #(
    parameter int unsigned MARK_DEPTH = npt_pkg::DEFAULT_MARK_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input requests.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] amount
    input  logic [1:0]                      s_tuser,   // [1:0] op
    // Results.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [71:0]                     m_tdata,   // [31:0] used_bytes,
                                                       // [63:32] popped_peak,
                                                       // [68:64] mark_count, rest zero
    output logic [1:0]                      m_tuser,   // [1:0] status
    // Configuration writes.
    input  logic                            cfg_wr_en,
    input  logic [npt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [npt_pkg::DATA_W-1:0]      cfg_wr_data
);
    import npt_pkg::*;

    // The mark level counts up to MARK_DEPTH itself; the memory index reaches
    // MARK_DEPTH - 1.
    localparam int unsigned LVL_W = $clog2(MARK_DEPTH + 1);
    localparam int unsigned IDX_W = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;

    logic [DATA_W-1:0]  binary_reg;
    logic [DATA_W-1:0]  stack_reg;

    logic               item_go;
    logic               item_ready;
    logic [DATA_W-1:0]  used_bytes;
    logic [DATA_W-1:0]  popped_peak;
    status_t            status;
    logic [COUNT_W-1:0] mark_count;
    mem_req_t           mem_req;
    logic [IDX_W-1:0]   mem_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic [ENTRY_W-1:0] mem_rd_data;

    // Output register holding one finished result.
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_used_reg;
    logic [DATA_W-1:0]  out_peak_reg;
    status_t            out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;

    // A request is taken when the core is not refilling its top mark and the
    // output register is empty or is being drained in this cycle.
    assign s_tready = item_ready && (!out_valid_reg || m_tready);
    assign item_go  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            binary_reg <= '0;
            stack_reg  <= STACK_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_BINARY_BYTES: binary_reg <= cfg_wr_data;
                REG_STACK_BYTES:  stack_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    npt_core #(
        .MARK_DEPTH (MARK_DEPTH),
        .LVL_W      (LVL_W),
        .IDX_W      (IDX_W)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_go      (item_go),
        .op           (op_t'(s_tuser)),
        .amount       (s_tdata),
        .binary_bytes (binary_reg),
        .stack_bytes  (stack_reg),
        .item_ready   (item_ready),
        .used_bytes   (used_bytes),
        .popped_peak  (popped_peak),
        .status       (status),
        .mark_count   (mark_count),
        .mem_req      (mem_req),
        .mem_addr     (mem_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_data  (mem_rd_data)
    );

    npt_mark_mem #(
        .DEPTH  (MARK_DEPTH),
        .ADDR_W (IDX_W)
    ) u_mark_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    always_comb begin
        if (item_go) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_go) begin
            out_used_reg   <= used_bytes;
            out_peak_reg   <= popped_peak;
            out_status_reg <= status;
            out_count_reg  <= mark_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_peak_reg, out_used_reg};
    assign m_tuser  = out_status_reg;

    `NPT_ASSERT_NEXT(a_result_follows, aclk, aresetn, item_go, out_valid_reg)
    `NPT_ASSERT_SAME(a_no_take_while_fill, aclk, aresetn, !item_ready, !s_tready)

endmodule

### rtl/core/npt_mark_mem.sv
module npt_mark_mem #(
    parameter int unsigned DEPTH  = npt_pkg::DEFAULT_MARK_DEPTH,
    parameter int unsigned ADDR_W = 4
) (
    input  logic                        aclk,
    input  npt_pkg::mem_req_t           req,
    input  logic [ADDR_W-1:0]           addr,
    input  logic [npt_pkg::ENTRY_W-1:0] wr_data,
    output logic [npt_pkg::ENTRY_W-1:0] rd_data
);
    import npt_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[addr] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/npt_core.sv
`include "nested_peak_usage_tracker_macros.svh"

module npt_core #(
    parameter int unsigned MARK_DEPTH = npt_pkg::DEFAULT_MARK_DEPTH,
    parameter int unsigned LVL_W      = 5,
    parameter int unsigned IDX_W      = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         item_go,
    input  npt_pkg::op_t                 op,
    input  logic [npt_pkg::DATA_W-1:0]   amount,
    input  logic [npt_pkg::DATA_W-1:0]   binary_bytes,
    input  logic [npt_pkg::DATA_W-1:0]   stack_bytes,
    output logic                         item_ready,
    output logic [npt_pkg::DATA_W-1:0]   used_bytes,
    output logic [npt_pkg::DATA_W-1:0]   popped_peak,
    output npt_pkg::status_t             status,
    output logic [npt_pkg::COUNT_W-1:0]  mark_count,
    output npt_pkg::mem_req_t            mem_req,
    output logic [IDX_W-1:0]             mem_addr,
    output logic [npt_pkg::ENTRY_W-1:0]  mem_wr_data,
    input  logic [npt_pkg::ENTRY_W-1:0]  mem_rd_data
);
    import npt_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_FILL = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] alloc_reg, alloc_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    // Top mark: its start usage and the maximum of the samples taken since it
    // was pushed. Marks below it live in memory.
    logic [DATA_W-1:0] top_start_reg, top_start_next;
    logic [DATA_W-1:0] top_smax_reg, top_smax_next;

    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] usage;
    logic [DATA_W-1:0] top_peak;
    logic [DATA_W-1:0] fill_smax;
    logic [LVL_W-1:0]  level_dec;
    logic [LVL_W-1:0]  level_dec2;
    logic              full;
    logic              empty;

    assign base       = binary_bytes + stack_bytes;
    assign full       = (level_reg == LVL_W'(MARK_DEPTH));
    assign empty      = (level_reg == '0);
    assign level_dec  = level_reg - LVL_W'(1);
    assign level_dec2 = level_reg - LVL_W'(2);
    assign top_peak   = (top_start_reg > top_smax_reg) ? top_start_reg : top_smax_reg;
    assign fill_smax  = (mem_rd_data[ENTRY_W-1:DATA_W] > top_smax_reg)
                      ? mem_rd_data[ENTRY_W-1:DATA_W] : top_smax_reg;

    assign item_ready = (state_reg == ST_RUN);

    always_comb begin
        alloc_next     = alloc_reg;
        level_next     = level_reg;
        top_start_next = top_start_reg;
        top_smax_next  = top_smax_reg;
        state_next     = state_reg;
        popped_peak    = '0;
        status         = STATUS_OK;
        mem_req        = '0;
        mem_addr       = level_dec[IDX_W-1:0];
        mem_wr_data    = {top_smax_reg, top_start_reg};

        // The allocation total only moves when a request is taken.
        if (item_go) begin
            unique case (op)
                OP_ALLOC:   alloc_next = alloc_reg + amount;
                OP_RELEASE: alloc_next = alloc_reg - amount;
                default:    alloc_next = alloc_reg;
            endcase
        end
        usage = base + alloc_next;

        unique case (state_reg)
            ST_RUN: begin
                if (item_go) begin
                    unique case (op)
                        OP_ALLOC, OP_RELEASE: begin
                            if (usage > top_smax_reg) begin
                                top_smax_next = usage;
                            end
                        end
                        OP_PUSH: begin
                            if (full) begin
                                status = STATUS_OVERFLOW;
                            end else begin
                                // The old top goes down into memory.
                                mem_req.wr_en  = !empty;
                                top_start_next = usage;
                                top_smax_next  = '0;
                                level_next     = level_reg + LVL_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (empty) begin
                                status = STATUS_UNDERFLOW;
                            end else begin
                                popped_peak = top_peak;
                                level_next  = level_dec;
                                if (level_reg != LVL_W'(1)) begin
                                    mem_req.rd_en = 1'b1;
                                    mem_addr      = level_dec2[IDX_W-1:0];
                                    state_next    = ST_FILL;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                // The mark below becomes the top; its samples include all of
                // those taken while the popped mark was open.
                top_start_next = mem_rd_data[DATA_W-1:0];
                top_smax_next  = fill_smax;
                state_next     = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    assign used_bytes = usage;
    assign mark_count = COUNT_W'(level_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            alloc_reg <= '0;
            level_reg <= '0;
        end else begin
            state_reg <= state_next;
            alloc_reg <= alloc_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_start_reg <= top_start_next;
        top_smax_reg  <= top_smax_next;
    end

    `NPT_ASSERT_SAME(a_level_bound, aclk, aresetn, 1'b1, level_reg <= LVL_W'(MARK_DEPTH))
    `NPT_ASSERT_SAME(a_mem_one_access, aclk, aresetn, 1'b1, !(mem_req.wr_en && mem_req.rd_en))
    `NPT_ASSERT_NEXT(a_fill_after_read, aclk, aresetn, mem_req.rd_en, state_reg == ST_FILL)
    `NPT_ASSERT_NEXT(a_fill_one_cycle, aclk, aresetn, state_reg == ST_FILL, state_reg == ST_RUN)

endmodule

### verif/npt_usage_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register ports of the usage tracker, keeps its own
// copy of the tracker state and checks every result against the oldest prediction.
module npt_usage_checker
    import npt_pkg::*;
#(
    parameter int unsigned MARK_DEPTH = DEFAULT_MARK_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [31:0]            s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [71:0]            m_tdata,
    input  logic [1:0]             m_tuser,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [DATA_W-1:0]      cfg_wr_data,
    output int                     errors,
    output int                     pending,
    output int                     checked
);

    typedef struct {
        logic [31:0] used;
        logic [31:0] popped;
        status_t     status;
        logic [4:0]  depth;
    } usage_result_t;

    localparam int MAX_PRINTED = 30;

    logic [31:0]   binary_q;
    logic [31:0]   stack_q;
    logic [31:0]   alloc_total_q;
    logic [31:0]   mark_peak_q [MARK_DEPTH];
    int unsigned   depth_q;
    usage_result_t results_due [$];

    initial begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    function automatic logic [31:0] usage_bytes();
        return binary_q + stack_q + alloc_total_q;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < MAX_PRINTED)
            $display("%0t checker: result %0d, %s: got 0x%08h, want 0x%08h",
                     $time, checked, field, got, want);
        errors++;
    endtask

    // Applies one request to the shadow state and returns what the tracker must answer.
    task automatic predict_usage(input op_t op, input logic [31:0] amount,
                                 output usage_result_t r);
        logic [31:0] level_now;
        r.popped = '0;
        r.status = STATUS_OK;
        case (op)
            OP_ALLOC, OP_RELEASE: begin
                alloc_total_q = (op == OP_ALLOC) ? alloc_total_q + amount
                                                 : alloc_total_q - amount;
                level_now = usage_bytes();
                for (int i = 0; i < MARK_DEPTH; i++)
                    if (i < depth_q && level_now > mark_peak_q[i])
                        mark_peak_q[i] = level_now;
            end
            OP_PUSH: begin
                if (depth_q >= MARK_DEPTH) begin
                    r.status = STATUS_OVERFLOW;
                end else begin
                    mark_peak_q[depth_q] = usage_bytes();
                    depth_q++;
                end
            end
            default: begin
                if (depth_q == 0) begin
                    r.status = STATUS_UNDERFLOW;
                end else begin
                    depth_q--;
                    r.popped = mark_peak_q[depth_q];
                end
            end
        endcase
        r.used  = usage_bytes();
        r.depth = depth_q[4:0];
    endtask

    always @(posedge aclk) begin
        usage_result_t want;
        usage_result_t fresh;
        if (!aresetn) begin
            binary_q      = '0;
            stack_q       = STACK_RESET;
            alloc_total_q = '0;
            depth_q       = 0;
            results_due.delete();
        end else begin
            // A result leaving in this cycle belongs to an earlier request.
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with no request outstanding", m_tdata[31:0], '0);
                end else begin
                    want = results_due.pop_front();
                    if (m_tdata[31:0] !== want.used)
                        report_mismatch("used_bytes", m_tdata[31:0], want.used);
                    if (m_tdata[63:32] !== want.popped)
                        report_mismatch("popped_peak", m_tdata[63:32], want.popped);
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[68:64] !== want.depth)
                        report_mismatch("mark_count", 32'(m_tdata[68:64]), 32'(want.depth));
                    if (m_tdata[71:69] !== 3'b000)
                        report_mismatch("tdata padding", 32'(m_tdata[71:69]), '0);
                end
                checked++;
            end
            if (s_tvalid && s_tready) begin
                predict_usage(op_t'(s_tuser), s_tdata, fresh);
                results_due.push_back(fresh);
            end
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_BINARY_BYTES: binary_q = cfg_wr_data;
                    REG_STACK_BYTES:  stack_q  = cfg_wr_data;
                    default: ;
                endcase
            end
        end
        pending = results_due.size();
    end

endmodule

### verif/tb_nested_peak_usage_tracker.sv
`timescale 1ns / 1ps

module tb_nested_peak_usage_tracker;
    import npt_pkg::*;

    localparam int    PERIOD_NS   = 12;
    localparam int    RESET_LEN   = 5;
    localparam int    PHASES      = 6;
    localparam int    PHASE_ITEMS = 146;
    localparam int    HOLD_OFF    = 120;
    localparam longint TIMEOUT_NS = 64'd2_400_000;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [DATA_W-1:0]     cfg_wr_data = '0;

    // Handshakes seen at the last rising edge; the stimulus looks at them at the
    // falling edge, so it never races the block's own registers.
    logic s_taken = 1'b0;
    logic m_taken = 1'b0;

    int errors;
    int pending;
    int checked;

    // Shared between the sender and the receiver processes.
    int hold_off_cycles = 0;
    bit no_idle         = 1'b0;

    int op_count [4];
    int settings_done = 0;
    logic [31:0] live_sizes [$];

    always #(PERIOD_NS / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
        m_taken <= m_tvalid && m_tready;
    end

    nested_peak_usage_tracker dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    npt_usage_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked)
    );

    // Offers one request after a random idle gap and returns at the falling edge
    // after it was taken. The valid stays high when the next request follows
    // without a gap.
    task automatic send_request(input op_t op, input logic [31:0] amount);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            s_tdata  = $urandom;    // noise on the data bus while idle
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = op;
        s_tdata  = amount;
        s_tvalid = 1'b1;
        do @(negedge aclk); while (!s_taken);
        op_count[op]++;
    endtask

    // Stops offering and waits until every predicted result has been taken; by then a pop
    // has also read back its mark. The task then idles on before anything else touches
    // the block.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // One random request. Allocations and releases mostly come in matching pairs,
    // the way an allocator sees them; a release of an unknown size is the noise.
    // Pushes and pops are weighted per phase to walk the mark stack up and down.
    task automatic random_request(input int push_w, input int pop_w);
        int          pick;
        int          slot;
        logic [31:0] amount;
        pick = $urandom_range(0, 99);
        if (pick < push_w) begin
            send_request(OP_PUSH, $urandom);
        end else if (pick < push_w + pop_w) begin
            send_request(OP_POP, $urandom);
        end else if ($urandom_range(0, 9) < 6) begin
            case ($urandom_range(0, 9))
                0:       amount = '0;
                1:       amount = 32'hFFFF_FFFF;
                2, 3:    amount = $urandom;
                default: amount = $urandom_range(1, 65536);
            endcase
            if (live_sizes.size() < 64)
                live_sizes.push_back(amount);
            send_request(OP_ALLOC, amount);
        end else begin
            if (live_sizes.size() != 0 && $urandom_range(0, 4) != 0) begin
                slot   = $urandom_range(0, live_sizes.size() - 1);
                amount = live_sizes[slot];
                live_sizes.delete(slot);
            end else begin
                case ($urandom_range(0, 2))
                    0:       amount = '0;
                    1:       amount = 32'hFFFF_FFFF;
                    default: amount = $urandom;
                endcase
            end
            send_request(OP_RELEASE, amount);
        end
    endtask

    // The receiver draws a stall before each result and, when asked, holds off
    // for a long stretch so that the block backs up into its request side.
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (hold_off_cycles > 0) begin
                m_tready = 1'b0;
                repeat (hold_off_cycles) @(negedge aclk);
                hold_off_cycles = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(negedge aclk); while (!m_taken && hold_off_cycles == 0);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_nested_peak_usage_tracker: done, errors");
        $finish;
    end

    initial begin
        logic [31:0] binary_set [PHASES];
        logic [31:0] stack_set  [PHASES];
        int          push_w     [PHASES];
        int          pop_w      [PHASES];

        // Register settings per phase: the reset values again, all ones, all zero,
        // random, the sign boundary, and small random sizes.
        binary_set = '{32'h0, 32'hFFFF_FFFF, 32'h0, $urandom, 32'h7FFF_FFFF,
                       $urandom_range(0, 4096)};
        stack_set  = '{32'h0002_0000, 32'hFFFF_FFFF, 32'h0, $urandom, 32'h8000_0000,
                       $urandom_range(0, 4096)};
        push_w     = '{15, 20, 15, 30, 20, 25};
        pop_w      = '{25, 20, 25, 10, 20, 20};
        op_count   = '{default: 0};

        repeat (RESET_LEN) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part, run with the reset register values. A pop with no mark
        // open, usage at the top of the range and wrapping past it, a release of
        // zero that still samples the peaks, and a release that wraps below zero.
        send_request(OP_POP,     32'h0000_0000);
        send_request(OP_ALLOC,   32'hFFFF_FFFF);
        send_request(OP_PUSH,    32'hFFFF_FFFF);
        send_request(OP_ALLOC,   32'h0000_0001);
        send_request(OP_RELEASE, 32'h0000_0000);
        send_request(OP_ALLOC,   32'h7FFF_0000);
        send_request(OP_RELEASE, 32'hFFFF_FFFF);
        send_request(OP_POP,     32'hFFFF_FFFF);
        send_request(OP_POP,     32'h0000_0000);
        // Fill the mark stack and push once more than it holds.
        for (int i = 0; i <= DEFAULT_MARK_DEPTH; i++)
            send_request(OP_PUSH, (i % 2) ? 32'hFFFF_FFFF : 32'h0);

        for (int p = 0; p < PHASES; p++) begin
            // Registers change only while the block is idle. Open marks carry over,
            // so a new setting is seen by their peaks only from the next allocate
            // or release.
            drain_results();
            write_reg(REG_BINARY_BYTES, binary_set[p]);
            write_reg(REG_STACK_BYTES,  stack_set[p]);
            settings_done++;
            no_idle = (p == 4);
            if (p == 1)
                hold_off_cycles = HOLD_OFF;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Halfway through one phase the sender waits for a full drain.
                if (p == 3 && n == PHASE_ITEMS / 2)
                    drain_results();
                random_request(push_w[p], pop_w[p]);
            end
        end

        no_idle = 1'b0;
        drain_results();
        repeat (10) @(negedge aclk);

        $display("Sent %0d requests (%0d allocate, %0d release, %0d push, %0d pop), %0d results checked.",
                 op_count[OP_ALLOC] + op_count[OP_RELEASE] + op_count[OP_PUSH] + op_count[OP_POP],
                 op_count[OP_ALLOC], op_count[OP_RELEASE], op_count[OP_PUSH], op_count[OP_POP],
                 checked);
        $display("Went through %0d register settings, a full mark stack, one long result stall and a drain.",
                 settings_done);
        if (errors == 0 && pending == 0) begin
            $display("tb_nested_peak_usage_tracker: done, clean");
        end else begin
            $display("tb_nested_peak_usage_tracker: done, errors");
        end
        $finish;
    end

endmodule
